>>> design/u8u16_pkg.sv
// Shared item types and code-point constants for the UTF-8 to UTF-16 offset map.
`timescale 1ns / 1ps

package u8u16_pkg;

    // Width of the byte offset carried in every result item.
    localparam int OFS_W = 17;

    // Code-point constants.
    localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

    // Most result items one input item can cause.
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0]      code_unit;
        logic [OFS_W-1:0] byte_offset;
        logic             is_terminal;
        logic             last;
    } t_out_item;

    // Result items of one input item, in emission order, and how many are valid.
    typedef struct packed {
        t_out_item [MAX_RES-1:0] units;
        logic [1:0]              count;
    } t_res_set;

endpackage

>>> design/u8u16_decode.sv
// Single-byte UTF-8 decode step: next decoder state and the result items of one byte.
`timescale 1ns / 1ps

module u8u16_decode #(
    parameter int POS_W    = 17,
    parameter int MaxBytes = 65536
) (
    input  u8u16_pkg::t_in_item i_item,
    input  logic [20:0]         i_pp,
    input  logic [1:0]          i_rem,
    input  logic [POS_W-1:0]    i_ss,
    input  logic [POS_W-1:0]    i_pos,
    output logic [20:0]         o_pp,
    output logic [1:0]          o_rem,
    output logic [POS_W-1:0]    o_ss,
    output logic [POS_W-1:0]    o_pos,
    output u8u16_pkg::t_res_set o_res
);
    import u8u16_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MaxBytes);

    function automatic t_out_item mk_unit(logic [15:0] unit, logic [POS_W-1:0] ofs);
        t_out_item e;
        e.code_unit   = unit;
        e.byte_offset = OFS_W'(ofs);
        e.is_terminal = 1'b0;
        e.last        = 1'b0;
        return e;
    endfunction

    function automatic logic is_pair(logic [20:0] cp);
        return cp > BMP_MAX;
    endfunction

    // First unit of a code point: the unit itself, or the high surrogate.
    function automatic logic [15:0] first_unit(logic [20:0] cp);
        logic [20:0] v;
        v = cp - SUPP_BASE;
        return is_pair(cp) ? 16'(SURR_HI_BASE + 16'(v[20:10])) : cp[15:0];
    endfunction

    function automatic logic [15:0] low_unit(logic [20:0] cp);
        logic [20:0] v;
        v = cp - SUPP_BASE;
        return 16'(SURR_LO_BASE + 16'(v[9:0]));
    endfunction

    t_out_item [3:0]  ent;
    logic [1:0]       k;
    logic [20:0]      pp;
    logic [1:0]       rem;
    logic [POS_W-1:0] ss;
    logic [POS_W-1:0] nxt;
    logic             lead;
    logic [7:0]       b;

    always_comb begin
        b    = i_item.data_byte;
        pp   = i_pp;
        rem  = i_rem;
        ss   = i_ss;
        lead = 1'b1;
        k    = 2'd0;
        ent  = '0;
        nxt  = (i_pos < MAX_POS) ? i_pos + 1'b1 : MAX_POS;

        // An open sequence either takes a continuation byte or is cut here.
        if (rem != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                pp   = {pp[14:0], b[5:0]};
                rem  = rem - 2'd1;
                lead = 1'b0;
                if (rem == 2'd0) begin
                    ent[k] = mk_unit(first_unit(pp), ss);
                    k      = k + 2'd1;
                    if (is_pair(pp)) begin
                        ent[k] = mk_unit(low_unit(pp), ss);
                        k      = k + 2'd1;
                    end
                    pp = '0;
                end
            end else begin
                ent[k] = mk_unit(first_unit(pp), ss);
                k      = k + 2'd1;
                if (is_pair(pp)) begin
                    ent[k] = mk_unit(low_unit(pp), ss);
                    k      = k + 2'd1;
                end
                pp  = '0;
                rem = 2'd0;
            end
        end

        if (lead) begin
            case (b) inside
                [8'h00:8'h7F]: begin
                    ent[k] = mk_unit({8'h00, b}, i_pos);
                    k      = k + 2'd1;
                end
                [8'hC0:8'hDF]: begin
                    pp  = {16'h0000, b[4:0]};
                    rem = 2'd1;
                    ss  = i_pos;
                end
                [8'hE0:8'hEF]: begin
                    pp  = {17'h00000, b[3:0]};
                    rem = 2'd2;
                    ss  = i_pos;
                end
                [8'hF0:8'hF7]: begin
                    pp  = {18'h00000, b[2:0]};
                    rem = 2'd3;
                    ss  = i_pos;
                end
                default: begin
                    // Stray continuation or invalid lead byte passes through.
                    ent[k] = mk_unit({8'h00, b}, i_pos);
                    k      = k + 2'd1;
                end
            endcase
        end

        if (i_item.final_byte) begin
            if (rem != 2'd0) begin
                ent[k] = mk_unit(first_unit(pp), ss);
                k      = k + 2'd1;
                if (is_pair(pp)) begin
                    ent[k] = mk_unit(low_unit(pp), ss);
                    k      = k + 2'd1;
                end
            end
            ent[k]             = mk_unit(16'h0000, nxt);
            ent[k].is_terminal = 1'b1;
            k                  = k + 2'd1;
            o_pp  = '0;
            o_rem = 2'd0;
            o_ss  = '0;
            o_pos = '0;
        end else begin
            o_pp  = pp;
            o_rem = rem;
            o_ss  = ss;
            o_pos = nxt;
        end

        if (k != 2'd0) begin
            ent[k - 2'd1].last = 1'b1;
        end

        o_res.units = ent[MAX_RES-1:0];
        o_res.count = k;
    end

endmodule

>>> design/u8u16_outq.sv
// Result register: holds the result items of one byte and hands them out one per cycle while i_ready is high.
`timescale 1ns / 1ps

module u8u16_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  u8u16_pkg::t_res_set  i_res,
    output logic                 o_can_load,
    output logic                 o_valid,
    input  logic                 i_ready,
    output u8u16_pkg::t_out_item o_item
);
    import u8u16_pkg::*;

    t_out_item [MAX_RES-1:0] r_q;
    logic [1:0]              r_cnt;
    logic                    pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_item     = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_res.units;
        end else if (pop) begin
            r_q <= {r_q[MAX_RES-1], r_q[MAX_RES-1:1]};
        end
    end

    // The head item is flagged last exactly when it is the only one left.
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_q[0].last)
        else $error("final buffered item lacks the last flag");

    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !r_q[0].last)
        else $error("last flag on an item that is not the final one");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("results loaded over items still waiting");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_load && (r_cnt > 2'd1)) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("buffer count did not step down on a handoff");

    a_terminal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.is_terminal) |-> (o_item.code_unit == 16'h0000 && o_item.last))
        else $error("terminal item carries a code unit or is not last");

endmodule

>>> design/utf8_to_utf16_offset_map_top.sv
// Top level of the UTF-8 to UTF-16 transcoder with per-unit byte-offset map.
// A byte is held in the input register, then its items in the result register.
// Throughput: one byte per cycle while the output is ready and each byte yields at
// most one result item; extra items of a byte hold the single result port in turn.
// Reset (synchronous, active low) empties both registers and returns the decoder
// to the start of a string at offset zero; no clearing pass is needed.
`timescale 1ns / 1ps

module utf8_to_utf16_offset_map_top #(
    parameter int MAX_STRING_BYTES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  u8u16_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output u8u16_pkg::t_out_item o_out_item
);
    import u8u16_pkg::*;

    // The byte position saturates at MAX_STRING_BYTES, so it must hold that value.
    localparam int POS_W = $clog2(MAX_STRING_BYTES + 1);

    // Input register: one accepted byte waiting to be decoded.
    logic             r_in_valid;
    t_in_item         r_in;

    // Decoder state: gathered code-point bits, continuation bytes still
    // expected, offset of the open sequence's lead byte, and the offset of
    // the next byte in the string.
    logic [20:0]      r_pp;
    logic [1:0]       r_rem;
    logic [POS_W-1:0] r_ss;
    logic [POS_W-1:0] r_pos;

    logic [20:0]      n_pp;
    logic [1:0]       n_rem;
    logic [POS_W-1:0] n_ss;
    logic [POS_W-1:0] n_pos;

    t_res_set         dec_res;
    logic             can_load;
    logic             load;

    // A buffered byte is decoded in the cycle the result register can take
    // all of its items: either it is empty, or its last item leaves now.
    // The decoder state advances in that same cycle, so each byte sees the
    // state left by the byte before it.
    assign load       = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pp       <= '0;
            r_rem      <= 2'd0;
            r_ss       <= '0;
            r_pos      <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_pp  <= n_pp;
                r_rem <= n_rem;
                r_ss  <= n_ss;
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // Shallow per-byte decode: continuation or cut of an open sequence,
    // the lead-byte class, then the end-of-string flush and terminal item.
    u8u16_decode #(
        .POS_W    (POS_W),
        .MaxBytes (MAX_STRING_BYTES)
    ) u_decode (
        .i_item (r_in),
        .i_pp   (r_pp),
        .i_rem  (r_rem),
        .i_ss   (r_ss),
        .i_pos  (r_pos),
        .o_pp   (n_pp),
        .o_rem  (n_rem),
        .o_ss   (n_ss),
        .o_pos  (n_pos),
        .o_res  (dec_res)
    );

    // Result register: up to three items of one byte, handed out in order.
    u8u16_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (dec_res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

endmodule
